// File: hw/rtl/smfa_pkg.sv
// Shared types and codes for the sign-magnitude 64.64 fixed-point ALU.
`default_nettype none
package smfa_pkg;

   localparam int WholeWidth = 64;
   localparam int FracWidth  = 64;
   localparam int MagWidth   = WholeWidth + FracWidth;
   localparam int TagWidth   = 3;
   localparam int KindWidth  = 3;
   localparam int CmpWidth   = 2;

   typedef enum logic [KindWidth-1:0] {
      KIND_ADD    = 3'd0,
      KIND_SUB    = 3'd1,
      KIND_NEGATE = 3'd2,
      KIND_HALVE  = 3'd3,
      KIND_DOUBLE = 3'd4,
      KIND_CMP    = 3'd5
   } kind_type;

   typedef logic [TagWidth-1:0] tag_type;

   localparam tag_type TAG_POS     = 3'd0;
   localparam tag_type TAG_NEG     = 3'd1;
   localparam tag_type TAG_ERR     = 3'd2;
   localparam tag_type TAG_OVF_POS = 3'd3;
   localparam tag_type TAG_OVF_NEG = 3'd4;
   localparam tag_type TAG_UNF_POS = 3'd5;
   localparam tag_type TAG_UNF_NEG = 3'd6;
   localparam tag_type TAG_BAD     = 3'd7;

   localparam logic signed [CmpWidth-1:0] CMP_LESS    = -2'sd1;
   localparam logic signed [CmpWidth-1:0] CMP_EQUAL   = 2'sd0;
   localparam logic signed [CmpWidth-1:0] CMP_GREATER = 2'sd1;

   typedef struct packed {
      logic [KindWidth-1:0]  kind;
      logic [WholeWidth-1:0] left_whole;
      logic [FracWidth-1:0]  left_frac;
      tag_type               left_tag;
      logic [WholeWidth-1:0] right_whole;
      logic [FracWidth-1:0]  right_frac;
      tag_type               right_tag;
   } operand_type;

   typedef struct packed {
      logic [WholeWidth-1:0]      res_whole;
      logic [FracWidth-1:0]       res_frac;
      tag_type                    res_tag;
      logic signed [CmpWidth-1:0] cmp_result;
   } result_type;

endpackage
`default_nettype wire

// File: hw/rtl/smfa_core.sv
// Combinational datapath: one 128-bit add, subtract, double, halve, negate or compare per item.
`default_nettype none
module smfa_core
   import smfa_pkg::*;
(
   input  operand_type op,
   output result_type  res
);

   logic [MagWidth-1:0] a_mag;
   logic [MagWidth-1:0] b_mag;
   logic                a_neg;
   logic                b_neg;
   logic                left_valid;
   logic                right_valid;
   logic [MagWidth:0]   sum;
   logic [MagWidth:0]   diff_ab;
   logic [MagWidth-1:0] diff_ba;
   logic                a_below_b;
   logic                mag_equal;
   logic [MagWidth-1:0] add_mag;
   tag_type             add_tag;
   logic [MagWidth-1:0] out_mag;
   logic                left_zero;
   logic [MagWidth-1:0] half_mag;
   tag_type             half_tag;

   assign a_mag       = {op.left_whole, op.left_frac};
   assign a_neg       = (op.left_tag == TAG_NEG);
   assign left_valid  = (op.left_tag == TAG_POS) || (op.left_tag == TAG_NEG);
   assign right_valid = (op.right_tag == TAG_POS) || (op.right_tag == TAG_NEG);
   assign left_zero   = (a_mag == '0);

   // Double reuses the adder with the left operand on both sides.
   always_comb begin
      b_mag = {op.right_whole, op.right_frac};
      b_neg = (op.right_tag == TAG_NEG);
      case (kind_type'(op.kind))
         KIND_SUB:    b_neg = !(op.right_tag == TAG_NEG);
         KIND_DOUBLE: begin
            b_mag = a_mag;
            b_neg = a_neg;
         end
         default:     ;
      endcase
   end

   assign sum       = {1'b0, a_mag} + {1'b0, b_mag};
   assign diff_ab   = {1'b0, a_mag} - {1'b0, b_mag};
   assign diff_ba   = b_mag - a_mag;
   assign a_below_b = diff_ab[MagWidth];
   assign mag_equal = (a_mag == b_mag);

   always_comb begin
      if (a_neg == b_neg) begin
         add_mag = sum[MagWidth-1:0];
         if (sum[MagWidth]) begin
            add_tag = a_neg ? TAG_OVF_NEG : TAG_OVF_POS;
         end else begin
            add_tag = a_neg ? TAG_NEG : TAG_POS;
         end
      end else if (mag_equal) begin
         // exact cancellation gives non-negative zero
         add_mag = '0;
         add_tag = TAG_POS;
      end else if (a_below_b) begin
         add_mag = diff_ba;
         add_tag = b_neg ? TAG_NEG : TAG_POS;
      end else begin
         add_mag = diff_ab[MagWidth-1:0];
         add_tag = a_neg ? TAG_NEG : TAG_POS;
      end
   end

   assign half_mag = {1'b0, a_mag[MagWidth-1:1]};

   always_comb begin
      half_tag = (op.left_tag == TAG_BAD) ? TAG_ERR : op.left_tag;
      if (a_mag[0]) begin
         half_tag = a_neg ? TAG_UNF_NEG : TAG_UNF_POS;
      end
   end

   always_comb begin
      out_mag        = '0;
      res.res_tag    = TAG_ERR;
      res.cmp_result = CMP_EQUAL;
      case (kind_type'(op.kind))
         KIND_ADD, KIND_SUB: begin
            if (left_valid && right_valid) begin
               out_mag     = add_mag;
               res.res_tag = add_tag;
            end
         end
         KIND_DOUBLE: begin
            if (left_valid) begin
               out_mag     = add_mag;
               res.res_tag = add_tag;
            end
         end
         KIND_NEGATE: begin
            if (left_valid) begin
               out_mag     = a_mag;
               res.res_tag = op.left_tag;
               if (!left_zero) begin
                  res.res_tag = a_neg ? TAG_POS : TAG_NEG;
               end
            end
         end
         KIND_HALVE: begin
            out_mag     = half_mag;
            res.res_tag = half_tag;
         end
         KIND_CMP: begin
            res.res_tag = TAG_POS;
            if (a_neg && !b_neg) begin
               res.cmp_result = CMP_LESS;
            end else if (!a_neg && b_neg) begin
               res.cmp_result = CMP_GREATER;
            end else if (mag_equal) begin
               res.cmp_result = CMP_EQUAL;
            end else if (a_below_b != a_neg) begin
               res.cmp_result = CMP_LESS;
            end else begin
               res.cmp_result = CMP_GREATER;
            end
         end
         default: ;
      endcase
      res.res_whole = out_mag[MagWidth-1:FracWidth];
      res.res_frac  = out_mag[FracWidth-1:0];
   end

endmodule
`default_nettype wire

// File: hw/rtl/sign_magnitude_fixed_point_alu.sv
// Sign-magnitude 64.64 ALU: input register, single-pass datapath, output register.
// Throughput one item per cycle while the result side does not stall.
// The rate is set by the one 128-bit add/subtract/compare pass between the two registers.
// Ready falls only when both registers hold items and the result side stalls.
// Synchronous active-high reset empties both registers; payload is not reset.
`default_nettype none
module sign_magnitude_fixed_point_alu
   import smfa_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // lowest bit up: left_whole, left_frac, left_tag, right_whole, right_frac,
   // right_tag, 2 zero bits
   input  wire logic [263:0] req_tdata,
   // kind
   input  wire logic [2:0]   req_tuser,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // lowest bit up: res_whole, res_frac, res_tag, cmp_result, 3 zero bits
   output logic [135:0]      rsp_tdata
);

   logic        in_valid_ff;
   logic        in_valid_in;
   operand_type in_data_ff;
   logic        out_valid_ff;
   logic        out_valid_in;
   result_type  out_data_ff;
   result_type  core_res;
   logic        out_room;
   logic        in_take;
   logic        out_load;

   assign out_room   = !out_valid_ff || rsp_tready;
   assign req_tready = !in_valid_ff || out_room;
   assign in_take    = req_tvalid && req_tready;
   assign out_load   = in_valid_ff && out_room;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (in_take) begin
         in_valid_in = 1'b1;
      end else if (out_load) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (out_load) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_take) begin
         in_data_ff.kind        <= req_tuser;
         in_data_ff.left_whole  <= req_tdata[63:0];
         in_data_ff.left_frac   <= req_tdata[127:64];
         in_data_ff.left_tag    <= req_tdata[130:128];
         in_data_ff.right_whole <= req_tdata[194:131];
         in_data_ff.right_frac  <= req_tdata[258:195];
         in_data_ff.right_tag   <= req_tdata[261:259];
      end
      if (out_load) begin
         out_data_ff <= core_res;
      end
   end

   smfa_core u_core (
      .op  (in_data_ff),
      .res (core_res)
   );

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {3'b000, out_data_ff.cmp_result, out_data_ff.res_tag,
                        out_data_ff.res_frac, out_data_ff.res_whole};

`ifndef SYNTH
   a_load_shows: assert property (@(posedge clock) disable iff (reset)
      out_load |=> rsp_tvalid)
      else $error("held item did not reach the output register");

   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (in_valid_ff && out_valid_ff && !rsp_tready))
      else $error("ready dropped with room in the pipeline");

   a_tag_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[130:128] != TAG_BAD))
      else $error("result carries an unused tag code");

   a_cmp_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[132:131] != 2'b10))
      else $error("compare outcome out of range");
`endif

endmodule
`default_nettype wire
